/* rtl/pbw_pkg.sv */
// ----------------------------------------------------------------------------
// pbw_pkg
// Shared types and constants of the perspective barycentric weight unit.
// ----------------------------------------------------------------------------
package pbw_pkg;

	localparam int FRAC_DEF = 16;
	localparam int QBITS = 32;
	localparam int IQ_DEPTH = 4;
	localparam int OQ_DEPTH = 2;
	localparam int THR_W = 31;
	localparam logic [THR_W-1:0] THR_RESET = 31'd655;
	localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_w;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_w;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_w;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} item_t;

	typedef struct packed {
		item_t fld;
		logic  wzero;
	} qitem_t;

	typedef struct packed {
		logic signed [31:0] weight_a;
		logic signed [31:0] weight_b;
		logic signed [31:0] weight_c;
		logic               invalid;
	} res_t;

endpackage

/* rtl/pbw_queue.sv */
// ----------------------------------------------------------------------------
// pbw_queue
// Small register queue, power-of-two depth, head shown while not empty.
// ----------------------------------------------------------------------------
module pbw_queue #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + AW'(1);
			if (do_pop) rp_q <= rp_q + AW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= din;
	end

endmodule

/* rtl/pbw_div.sv */
// ----------------------------------------------------------------------------
// pbw_div
// Pipelined signed divider, trunc(num * 2^F / den) saturated to 32 bits,
// one quotient bit per stage, several lanes sharing one sideband.
// ----------------------------------------------------------------------------
module pbw_div #(
	parameter int LANES = 1,
	parameter int NW = 32,
	parameter int DW = 32,
	parameter int F = 16,
	parameter int SW = 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [LANES-1:0][NW-1:0]             num,
	input  logic [LANES-1:0][DW-1:0]             den,
	input  logic [SW-1:0]                        sb_in,
	output logic                                 out_valid,
	output logic [LANES-1:0][pbw_pkg::QBITS-1:0] quo,
	output logic [SW-1:0]                        sb_out
);
	import pbw_pkg::*;

	localparam int NX = NW + F;
	localparam int CW = (NX > DW) ? NX : DW;

	logic [LANES-1:0][NW-1:0] nm_s0;
	logic [LANES-1:0][DW-1:0] dm_s0;
	logic [LANES-1:0]         ng_s0;
	logic [SW-1:0]            sb_s0;
	logic                     vld_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s0 <= 1'b0;
		else if (en) vld_s0 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				nm_s0[l] <= num[l][NW-1] ? NW'(-num[l]) : num[l];
				dm_s0[l] <= den[l][DW-1] ? DW'(-den[l]) : den[l];
				ng_s0[l] <= num[l][NW-1] ^ den[l][DW-1];
			end
			sb_s0 <= sb_in;
		end
	end

	// quotient bits above bit 31 only decide saturation
	logic [LANES-1:0][DW-1:0]    rem_i;
	logic [LANES-1:0][QBITS-1:0] lo_i;
	logic [LANES-1:0]            big_i;

	always_comb begin
		logic [NX-1:0] nx;
		logic [NX-1:0] hi;
		for (int l = 0; l < LANES; l++) begin
			nx       = NX'(nm_s0[l]) << F;
			hi       = nx >> QBITS;
			big_i[l] = CW'(hi) >= CW'(dm_s0[l]);
			rem_i[l] = big_i[l] ? '0 : DW'(hi);
			lo_i[l]  = nx[QBITS-1:0];
		end
	end

	logic [LANES-1:0][DW-1:0]    rem_q [QBITS+1];
	logic [LANES-1:0][QBITS-1:0] quo_q [QBITS+1];
	logic [LANES-1:0][QBITS-1:0] lo_q  [QBITS+1];
	logic [LANES-1:0][DW-1:0]    den_q [QBITS+1];
	logic [LANES-1:0]            ng_q  [QBITS+1];
	logic [LANES-1:0]            big_q [QBITS+1];
	logic [SW-1:0]               sb_q  [QBITS+1];
	logic                        vld_q [QBITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q[0] <= 1'b0;
		else if (en) vld_q[0] <= vld_s0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= rem_i;
			quo_q[0] <= '0;
			lo_q[0]  <= lo_i;
			den_q[0] <= dm_s0;
			ng_q[0]  <= ng_s0;
			big_q[0] <= big_i;
			sb_q[0]  <= sb_s0;
		end
	end

	for (genvar k = 0; k < QBITS; k++) begin : g_step
		logic [LANES-1:0][DW-1:0] rem_n;
		logic [LANES-1:0]         qb;

		always_comb begin
			logic [DW:0] trial;
			for (int l = 0; l < LANES; l++) begin
				trial    = {rem_q[k][l], lo_q[k][l][QBITS-1]};
				qb[l]    = trial >= {1'b0, den_q[k][l]};
				rem_n[l] = qb[l] ? DW'(trial - {1'b0, den_q[k][l]}) : trial[DW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q[k+1] <= 1'b0;
			else if (en) vld_q[k+1] <= vld_q[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					quo_q[k+1][l] <= {quo_q[k][l][QBITS-2:0], qb[l]};
					lo_q[k+1][l]  <= lo_q[k][l] << 1;
				end
				rem_q[k+1] <= rem_n;
				den_q[k+1] <= den_q[k];
				ng_q[k+1]  <= ng_q[k];
				big_q[k+1] <= big_q[k];
				sb_q[k+1]  <= sb_q[k];
			end
		end
	end

	logic [LANES-1:0][QBITS-1:0] quo_n;

	always_comb begin
		logic [QBITS-1:0] q;
		for (int l = 0; l < LANES; l++) begin
			q = quo_q[QBITS][l];
			if (ng_q[QBITS][l])
				quo_n[l] = (big_q[QBITS][l] || q > SAT_MIN) ? SAT_MIN : QBITS'(-q);
			else
				quo_n[l] = (big_q[QBITS][l] || q[QBITS-1]) ? SAT_MAX : q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vld_q[QBITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo    <= quo_n;
			sb_out <= sb_q[QBITS];
		end
	end

endmodule

/* rtl/pbw_front.sv */
// ----------------------------------------------------------------------------
// pbw_front
// Intake: flags a zero w on any vertex and queues the item for the back end.
// ----------------------------------------------------------------------------
module pbw_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pbw_pkg::item_t  item_in,
	output logic            full,
	input  logic            item_take,
	output logic            item_avail,
	output pbw_pkg::qitem_t item
);
	import pbw_pkg::*;

	qitem_t qin;
	logic   empty;

	assign qin.fld   = item_in;
	assign qin.wzero = (item_in.a_w == '0) || (item_in.b_w == '0) || (item_in.c_w == '0);
	assign item_avail = !empty;

	pbw_queue #(
		.W     ($bits(qitem_t)),
		.DEPTH (IQ_DEPTH)
	) u_iq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (qin),
		.full   (full),
		.pop    (item_take),
		.dout   (item),
		.empty  (empty)
	);

endmodule

/* rtl/pbw_back.sv */
// ----------------------------------------------------------------------------
// pbw_back
// Arithmetic pipeline: projection, edge cross products, area test,
// barycentrics, perspective correction. Stalls as one on a full result queue.
// ----------------------------------------------------------------------------
module pbw_back #(
	parameter int FRAC_BITS = pbw_pkg::FRAC_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [pbw_pkg::THR_W-1:0]  threshold,
	input  logic                       item_avail,
	input  pbw_pkg::qitem_t            item,
	output logic                       item_take,
	input  logic                       res_full,
	output logic                       res_push,
	output pbw_pkg::res_t              res
);
	import pbw_pkg::*;

	localparam logic [31:0] ONE32   = 32'(1) << FRAC_BITS;
	localparam logic [31:0] NEG_ONE = ~ONE32 + 32'd1;
	localparam logic [33:0] ONE34   = 34'(1) << FRAC_BITS;

	function automatic logic [31:0] sub_sat(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		d = {a[31], a} - {b[31], b};
		sub_sat = (d[32] != d[31]) ? (d[32] ? SAT_MIN : SAT_MAX) : d[31:0];
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	assign en        = !(v_s8 && res_full);
	assign item_take = en && item_avail;
	assign res_push  = v_s8 && !res_full;

	// projection
	logic [5:0][31:0] p_num, p_den, p_q;
	logic [160:0]     p_sb_in, p_sb;
	logic             p_v;
	logic [31:0]      p_aw, p_bw, p_cw, p_px, p_py;
	logic             p_wz;

	assign p_num = {item.fld.c_y, item.fld.c_x, item.fld.b_y, item.fld.b_x,
		item.fld.a_y, item.fld.a_x};
	assign p_den = {item.fld.c_w, item.fld.c_w, item.fld.b_w, item.fld.b_w,
		item.fld.a_w, item.fld.a_w};
	assign p_sb_in = {item.wzero, item.fld.a_w, item.fld.b_w, item.fld.c_w,
		item.fld.point_x, item.fld.point_y};
	assign {p_wz, p_aw, p_bw, p_cw, p_px, p_py} = p_sb;

	pbw_div #(.LANES(6), .NW(32), .DW(32), .F(FRAC_BITS), .SW(161)) u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (item_avail),
		.num       (p_num),
		.den       (p_den),
		.sb_in     (p_sb_in),
		.out_valid (p_v),
		.quo       (p_q),
		.sb_out    (p_sb)
	);

	logic signed [31:0] acx_s1, acy_s1, abx_s1, aby_s1, pax_s1, pay_s1;
	logic signed [63:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [63:0] k0_s3, k1_s3, k2_s3;
	logic signed [63:0] k0_s4, k1_s4, k2_s4;
	logic        [63:0] k2m_s4;
	logic signed [63:0] k0_s5, k1_s5, k2_s5;
	logic               bad_s5;
	logic [31:0] aw_s1, bw_s1, cw_s1, aw_s2, bw_s2, cw_s2, aw_s3, bw_s3, cw_s3;
	logic [31:0] aw_s4, bw_s4, cw_s4, aw_s5, bw_s5, cw_s5;
	logic        wz_s1, wz_s2, wz_s3, wz_s4;
	logic [63:0] lim;

	assign lim = 64'(threshold) << FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= p_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acx_s1 <= sub_sat(p_q[4], p_q[0]);
			acy_s1 <= sub_sat(p_q[5], p_q[1]);
			abx_s1 <= sub_sat(p_q[2], p_q[0]);
			aby_s1 <= sub_sat(p_q[3], p_q[1]);
			pax_s1 <= sub_sat(p_q[0], p_px);
			pay_s1 <= sub_sat(p_q[1], p_py);
			{wz_s1, aw_s1, bw_s1, cw_s1} <= {p_wz, p_aw, p_bw, p_cw};

			p0_s2 <= abx_s1 * pay_s1;
			p1_s2 <= pax_s1 * aby_s1;
			p2_s2 <= pax_s1 * acy_s1;
			p3_s2 <= acx_s1 * pay_s1;
			p4_s2 <= acx_s1 * aby_s1;
			p5_s2 <= abx_s1 * acy_s1;
			{wz_s2, aw_s2, bw_s2, cw_s2} <= {wz_s1, aw_s1, bw_s1, cw_s1};

			k0_s3 <= p0_s2 - p1_s2;
			k1_s3 <= p2_s2 - p3_s2;
			k2_s3 <= p4_s2 - p5_s2;
			{wz_s3, aw_s3, bw_s3, cw_s3} <= {wz_s2, aw_s2, bw_s2, cw_s2};

			k2m_s4 <= k2_s3[63] ? -k2_s3 : k2_s3;
			{k0_s4, k1_s4, k2_s4} <= {k0_s3, k1_s3, k2_s3};
			{wz_s4, aw_s4, bw_s4, cw_s4} <= {wz_s3, aw_s3, bw_s3, cw_s3};

			bad_s5 <= wz_s4 || (k2m_s4 <= lim);
			{k0_s5, k1_s5, k2_s5} <= {k0_s4, k1_s4, k2_s4};
			{aw_s5, bw_s5, cw_s5} <= {aw_s4, bw_s4, cw_s4};
		end
	end

	// screen barycentrics u, v
	logic [1:0][31:0] uv_q;
	logic [96:0]      uv_sb;
	logic             uv_v;
	logic             uv_bad;
	logic [31:0]      uv_aw, uv_bw, uv_cw;

	assign {uv_bad, uv_aw, uv_bw, uv_cw} = uv_sb;

	pbw_div #(.LANES(2), .NW(64), .DW(64), .F(FRAC_BITS), .SW(97)) u_bary (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.num       ({k0_s5, k1_s5}),
		.den       ({k2_s5, k2_s5}),
		.sb_in     ({bad_s5, aw_s5, bw_s5, cw_s5}),
		.out_valid (uv_v),
		.quo       (uv_q),
		.sb_out    (uv_sb)
	);

	logic [33:0] al_s6, u_s6, v_s6x;
	logic [31:0] aw_s6, bw_s6, cw_s6;
	logic        bad_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			al_s6  <= ONE34 - {{2{uv_q[0][31]}}, uv_q[0]} - {{2{uv_q[1][31]}}, uv_q[1]};
			u_s6   <= {{2{uv_q[0][31]}}, uv_q[0]};
			v_s6x  <= {{2{uv_q[1][31]}}, uv_q[1]};
			bad_s6 <= uv_bad;
			{aw_s6, bw_s6, cw_s6} <= {uv_aw, uv_bw, uv_cw};
		end
	end

	// perspective terms
	logic [2:0][31:0] t_q;
	logic             t_sb, t_v;

	pbw_div #(.LANES(3), .NW(34), .DW(32), .F(FRAC_BITS), .SW(1)) u_persp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       ({v_s6x, u_s6, al_s6}),
		.den       ({cw_s6, bw_s6, aw_s6}),
		.sb_in     (bad_s6),
		.out_valid (t_v),
		.quo       (t_q),
		.sb_out    (t_sb)
	);

	logic [33:0] ta_s7, tb_s7, tc_s7, sum_s7;
	logic        bad_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			ta_s7  <= {{2{t_q[0][31]}}, t_q[0]};
			tb_s7  <= {{2{t_q[1][31]}}, t_q[1]};
			tc_s7  <= {{2{t_q[2][31]}}, t_q[2]};
			sum_s7 <= {{2{t_q[0][31]}}, t_q[0]} + {{2{t_q[1][31]}}, t_q[1]}
				+ {{2{t_q[2][31]}}, t_q[2]};
			bad_s7 <= t_sb;
		end
	end

	// normalised weights
	logic [2:0][31:0] w_q;
	logic             w_sb, w_v;

	pbw_div #(.LANES(3), .NW(34), .DW(34), .F(FRAC_BITS), .SW(1)) u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.num       ({tc_s7, tb_s7, ta_s7}),
		.den       ({sum_s7, sum_s7, sum_s7}),
		.sb_in     (bad_s7 || (sum_s7 == '0)),
		.out_valid (w_v),
		.quo       (w_q),
		.sb_out    (w_sb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s6 <= uv_v;
			v_s7 <= t_v;
			v_s8 <= w_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.weight_a <= w_sb ? NEG_ONE : w_q[0];
			res.weight_b <= w_sb ? NEG_ONE : w_q[1];
			res.weight_c <= w_sb ? NEG_ONE : w_q[2];
			res.invalid  <= w_sb;
		end
	end

endmodule

/* rtl/perspective_barycentric_weights.sv */
// ----------------------------------------------------------------------------
// perspective_barycentric_weights
// Perspective-correct barycentric weights of a screen point, signed Q.F.
// ----------------------------------------------------------------------------
// Input side is a queue: an item (three vertices x, y, w and a point) is
// transferred when push is high and full is low. Results come out of a
// queue: while empty is low the oldest result is on weight_a/b/c and
// invalid, and it is transferred when pop is high.
// One item per cycle sustained while the receiver keeps popping. An item
// passes from the input transfer to empty going low through four pipelined
// dividers of 35 stages each (a quotient bit in each of their step stages)
// plus eight arithmetic stages and the two queues.
// The area threshold is written on cfg_valid/cfg_data (cfg_ready is always
// high), by the user only while the block is idle; it is not enforced.
// Reset loads 655 (about 0.01 at Q16.16) and empties the queues and pipeline.
// If the receiver stops popping, the pipeline holds as one once the result
// queue is full, and full rises when the four-entry input queue fills.
// ----------------------------------------------------------------------------
module perspective_barycentric_weights #(
	parameter int FRAC_BITS = pbw_pkg::FRAC_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic signed [31:0]        a_x,
	input  logic signed [31:0]        a_y,
	input  logic signed [31:0]        a_w,
	input  logic signed [31:0]        b_x,
	input  logic signed [31:0]        b_y,
	input  logic signed [31:0]        b_w,
	input  logic signed [31:0]        c_x,
	input  logic signed [31:0]        c_y,
	input  logic signed [31:0]        c_w,
	input  logic signed [31:0]        point_x,
	input  logic signed [31:0]        point_y,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [31:0]        weight_a,
	output logic signed [31:0]        weight_b,
	output logic signed [31:0]        weight_c,
	output logic                      invalid,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [pbw_pkg::THR_W-1:0] cfg_data
);
	import pbw_pkg::*;

	logic [THR_W-1:0] thr_q;
	item_t            item_in;
	qitem_t           item;
	logic             item_avail, item_take;
	res_t             res, res_out;
	logic             res_push, res_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= THR_RESET;
		else if (cfg_valid) thr_q <= cfg_data;
	end

	assign item_in = '{a_x: a_x, a_y: a_y, a_w: a_w, b_x: b_x, b_y: b_y, b_w: b_w,
		c_x: c_x, c_y: c_y, c_w: c_w, point_x: point_x, point_y: point_y};

	pbw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item_in    (item_in),
		.full       (full),
		.item_take  (item_take),
		.item_avail (item_avail),
		.item       (item)
	);

	pbw_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.threshold  (thr_q),
		.item_avail (item_avail),
		.item       (item),
		.item_take  (item_take),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	pbw_queue #(
		.W     ($bits(res_t)),
		.DEPTH (OQ_DEPTH)
	) u_oq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign weight_a = res_out.weight_a;
	assign weight_b = res_out.weight_b;
	assign weight_c = res_out.weight_c;
	assign invalid  = res_out.invalid;

endmodule
